FILE: src/ciss_pkg.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring search package
// Shared constants, types and the letter case fold used by the search block.
// ----------------------------------------------------------------------------
`default_nettype none

package ciss_pkg;

	// Pattern capacity and buffer bound.
	localparam int MAX_PATTERN = 8;
	localparam int MAX_BUFFER  = 65536;

	// Characters actually held: the pattern register carries at most eight.
	localparam int PAT_CAP = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;

	// Field and register widths.
	localparam int BYTE_W     = 8;
	localparam int PATTERN_W  = 64;
	localparam int LEN_W      = 4;
	localparam int OFFSET_W   = 17;
	localparam int CNT_W      = $clog2(MAX_BUFFER + 1);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);

	typedef logic [BYTE_W-1:0]             byte_t;
	typedef logic [PAT_CAP-1:0][BYTE_W-1:0] window_t;

	// Map upper-case ASCII letters onto lower case; other bytes pass as they are.
	function automatic byte_t fold_case(input byte_t c);
		byte_t r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/ciss_if.sv
// ----------------------------------------------------------------------------
// Search block channel interfaces
// Valid/ready channels for the byte stream and for the search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ciss_byte_if;
	import ciss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ciss_result_if;
	import ciss_pkg::*;

	logic                valid;
	logic                ready;
	logic                found;
	logic [OFFSET_W-1:0] end_offset;

	modport source (output valid, output found, output end_offset, input ready);
	modport sink   (input valid, input found, input end_offset, output ready);
endinterface

`default_nettype wire

FILE: src/ciss_window_cmp.sv
// ----------------------------------------------------------------------------
// Window compare
// Compares the newest bytes of the window with the pattern, letters folded,
// for every possible length in parallel, and picks the active length.
// ----------------------------------------------------------------------------
`default_nettype none

module ciss_window_cmp
(
	input  ciss_pkg::window_t                  window,
	input  logic [ciss_pkg::PATTERN_W-1:0]     pattern,
	input  logic [ciss_pkg::LEN_W-1:0]         len,
	output logic                               match
);
	import ciss_pkg::*;

	logic [PAT_CAP-1:0] len_ok;

	// Pattern character k lines up with the byte taken len-1-k transfers ago.
	always_comb begin
		for (int l = 0; l < PAT_CAP; l++) begin
			len_ok[l] = 1'b1;
			for (int k = 0; k < PAT_CAP; k++) begin
				if (k <= l) begin
					if (fold_case(pattern[k*BYTE_W +: BYTE_W]) !=
					    fold_case(window[l-k])) begin
						len_ok[l] = 1'b0;
					end
				end
			end
		end
	end

	// Select the result for the active length.
	always_comb begin
		match = 1'b0;
		for (int l = 0; l < PAT_CAP; l++) begin
			if (len == LEN_W'(l + 1)) begin
				match = len_ok[l];
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/case_insensitive_substring_search.sv
// ----------------------------------------------------------------------------
// Case-insensitive substring search
// Finds the first occurrence of a 1 to 8 byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the stream channel, the final byte
// of a buffer marked by last_byte. A byte is held in the input
// register, where the shifted window is compared against the pattern with
// ASCII letters folded to one case; the outcome lands in the result
// register, and the sustained rate is one byte per cycle while results are
// taken. Each buffer yields exactly one result: found with the offset just
// past the first match, or not-found on the final byte. Bytes after a match
// up to the end of the buffer yield nothing. The byte count saturates at
// the buffer bound. Configuration is to be written between buffers through
// the plain write port; the block does not enforce this. Index 0 is the
// packed pattern, index 1 the pattern length (0 reads as 1, above 8 as 8).
`default_nettype none

module case_insensitive_substring_search
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ciss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ciss_pkg::CFG_DATA_W-1:0]    cfg_data,
	ciss_byte_if.sink                          stream,
	ciss_result_if.source                      result
);
	import ciss_pkg::*;

	// Configuration registers.
	logic [PATTERN_W-1:0] pattern_q;
	logic [LEN_W-1:0]     plen_q;

	// Input register.
	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;

	// Per-buffer search state.
	window_t          recent_q;
	logic [CNT_W-1:0] seen_q;
	logic             reported_q;

	// Result register.
	logic                out_valid_q;
	logic                found_q;
	logic [OFFSET_W-1:0] offset_q;

	window_t          window_nxt;
	logic [CNT_W-1:0] seen_nxt;
	logic [LEN_W-1:0] len;
	logic             match;
	logic             hit;
	logic             emit;
	logic             out_free;
	logic             s1_go;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= LEN_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_PATTERN_BYTES) begin
				pattern_q <= PATTERN_W'(cfg_data);
			end else if (cfg_index == REG_PATTERN_LENGTH) begin
				plen_q <= cfg_data[LEN_W-1:0];
			end
		end
	end

	// Active pattern length, clamped to the range the window holds.
	always_comb begin
		if (plen_q == '0) begin
			len = LEN_W'(1);
		end else if (plen_q > LEN_W'(PAT_CAP)) begin
			len = LEN_W'(PAT_CAP);
		end else begin
			len = plen_q;
		end
	end

	// Window after the byte in the input register is shifted in.
	always_comb begin
		window_nxt[0] = data_s1;
		for (int k = 1; k < PAT_CAP; k++) begin
			window_nxt[k] = recent_q[k-1];
		end
	end

	assign seen_nxt = (seen_q == CNT_W'(MAX_BUFFER)) ? seen_q : seen_q + CNT_W'(1);

	ciss_window_cmp u_cmp (
		.window  (window_nxt),
		.pattern (pattern_q),
		.len     (len),
		.match   (match)
	);

	// A byte produces a result on the first match or at the end of the buffer.
	assign hit      = !reported_q && (seen_nxt >= CNT_W'(len)) && match;
	assign emit     = !reported_q && (hit || last_s1);
	assign out_free = !out_valid_q || result.ready;
	assign s1_go    = valid_s1 && (!emit || out_free);

	assign stream.ready = !valid_s1 || s1_go;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	// Search state advances as each byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				recent_q   <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				recent_q <= window_nxt;
				seen_q   <= seen_nxt;
				if (hit) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	// Result register holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			found_q  <= hit;
			offset_q <= hit ? OFFSET_W'(seen_nxt) : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.found      = found_q;
	assign result.end_offset = offset_q;

endmodule

`default_nettype wire
